// ===== rtl/smdmp_pkg.sv =====
// ----------------------------------------------------------------------------
// smdmp_pkg
// Shared widths and defaults for the sorted list merge block.
// ----------------------------------------------------------------------------
package smdmp_pkg;

  // default number of entries per list
  localparam int unsigned LIST_DEPTH_DEF = 32;

  // record field widths
  localparam int unsigned ID_W  = 16;
  localparam int unsigned PR_W  = 16;
  localparam int unsigned REC_W = ID_W + PR_W;

  // running statistics widths
  localparam int unsigned CNT_W = 7;
  localparam int unsigned TOT_W = 22;

endpackage

// ===== rtl/smdmp_ram.sv =====
// ----------------------------------------------------------------------------
// smdmp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smdmp_ram #(
  parameter int unsigned WIDTH = smdmp_pkg::REC_W,
  parameter int unsigned DEPTH = smdmp_pkg::LIST_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sorted_merge_dedup_min_price.sv =====
// ----------------------------------------------------------------------------
// sorted_merge_dedup_min_price
// Two sorted (id, price) lists in RAM, merged; equal ids at both heads give one result.
// ----------------------------------------------------------------------------
// Insert: a record for a full list is dropped and sets the overflow flag; one for
//   an empty list is written at entry 0; else a backward walk over the list RAM
//   moves entries up until the place of the new record is found.
// Merge (record marked last): insert, a setup state, then one result per cycle,
//   registered in the cycle after each merge step. busy_o is high throughout.
// Results cannot be stalled. Reset empties both lists and clears the overflow flag.
module sorted_merge_dedup_min_price #(
  parameter int unsigned LIST_DEPTH = smdmp_pkg::LIST_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        list_select_i,
  input  logic [smdmp_pkg::ID_W-1:0]  product_id_i,
  input  logic [smdmp_pkg::PR_W-1:0]  price_i,
  input  logic                        last_item_i,
  output logic                        result_valid_o,
  output logic [smdmp_pkg::ID_W-1:0]  product_id_res_o,
  output logic [smdmp_pkg::PR_W-1:0]  price_res_o,
  output logic                        source_list_o,
  output logic [smdmp_pkg::CNT_W-1:0] running_count_o,
  output logic [smdmp_pkg::TOT_W-1:0] running_total_o,
  output logic                        overflow_o,
  output logic                        last_result_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IW = smdmp_pkg::ID_W;
  localparam int unsigned PW = smdmp_pkg::PR_W;
  localparam int unsigned RW = smdmp_pkg::REC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_WR0  = 3'd2;
  localparam logic [2:0] S_MST  = 3'd3;
  localparam logic [2:0] S_MRG  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_a_q, fill_a_d, fill_b_q, fill_b_d;
  logic          flag_q, flag_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [smdmp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [smdmp_pkg::TOT_W-1:0] tot_q, tot_d;

  // latched record
  logic          sel_q, last_q;
  logic [IW-1:0] id_q;
  logic [PW-1:0] pr_q;

  // RAM ports
  logic          we_a, we_b, we;
  logic [AW-1:0] waddr, raddr_a, raddr_b, ins_raddr;
  logic [RW-1:0] wdata, rdata_a, rdata_b, rdata_s;
  logic [CW-1:0] n_in;

  // merge step
  logic          a_ok, b_ok, take_a, take_b, pick_a;
  logic [IW-1:0] aid, bid;
  logic [PW-1:0] apr, bpr, opr;
  logic          res_valid_d;

  smdmp_ram #(.WIDTH(RW), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  smdmp_ram #(.WIDTH(RW), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  assign busy_o  = (state_q != S_IDLE);
  assign n_in    = list_select_i ? fill_b_q : fill_a_q;
  assign rdata_s = sel_q ? rdata_b : rdata_a;
  assign we_a    = we & ~sel_q;
  assign we_b    = we & sel_q;

  // merge head compare
  assign aid    = rdata_a[RW-1:PW];
  assign apr    = rdata_a[PW-1:0];
  assign bid    = rdata_b[RW-1:PW];
  assign bpr    = rdata_b[PW-1:0];
  assign a_ok   = (ia_q < fill_a_q);
  assign b_ok   = (ib_q < fill_b_q);
  assign take_a = ~b_ok | (a_ok & (aid < bid));
  assign take_b = ~take_a & (~a_ok | (aid > bid));
  assign pick_a = take_a | (~take_b & (apr <= bpr));
  assign opr    = pick_a ? apr : bpr;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    fill_a_d    = fill_a_q;
    fill_b_d    = fill_b_q;
    flag_d      = flag_q;
    idx_d       = idx_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    we          = 1'b0;
    waddr       = idx_q + AW'(1);
    wdata       = {id_q, pr_q};
    ins_raddr   = idx_q - AW'(1);
    res_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ins_raddr = AW'(n_in - CW'(1));
        if (start_i) begin
          idx_d = AW'(n_in - CW'(1));
          if (n_in >= CW'(LIST_DEPTH)) begin
            flag_d  = 1'b1;
            state_d = last_item_i ? S_MST : S_IDLE;
          end else begin
            if (list_select_i) fill_b_d = fill_b_q + CW'(1);
            else               fill_a_d = fill_a_q + CW'(1);
            state_d = (n_in == '0) ? S_WR0 : S_INS;
          end
        end
      end
      S_INS: begin
        // move entry up while it does not precede the new record
        we = 1'b1;
        if ((idx_q == '0) ? (id_q < rdata_s[RW-1:PW]) : (rdata_s[RW-1:PW] >= id_q)) begin
          wdata = rdata_s;
          if (idx_q == '0) state_d = S_WR0;
          else             idx_d   = idx_q - AW'(1);
        end else begin
          state_d = last_q ? S_MST : S_IDLE;
        end
      end
      S_WR0: begin
        we      = 1'b1;
        waddr   = '0;
        state_d = last_q ? S_MST : S_IDLE;
      end
      S_MST: begin
        ia_d    = '0;
        ib_d    = '0;
        cnt_d   = '0;
        tot_d   = '0;
        state_d = S_MRG;
      end
      S_MRG: begin
        res_valid_d = 1'b1;
        if (~take_b) ia_d = ia_q + CW'(1);
        if (~take_a) ib_d = ib_q + CW'(1);
        cnt_d = cnt_q + smdmp_pkg::CNT_W'(1);
        tot_d = tot_q + smdmp_pkg::TOT_W'(opr);
        if ((ia_d >= fill_a_q) && (ib_d >= fill_b_q)) begin
          fill_a_d = '0;
          fill_b_d = '0;
          flag_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // read address select: merge walks heads, insert walks down
  always_comb begin
    raddr_a = ins_raddr;
    raddr_b = ins_raddr;
    if (state_q == S_MST) begin
      raddr_a = '0;
      raddr_b = '0;
    end else if (state_q == S_MRG) begin
      raddr_a = ia_d[AW-1:0];
      raddr_b = ib_d[AW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fill_a_q       <= '0;
      fill_b_q       <= '0;
      flag_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      fill_a_q       <= fill_a_d;
      fill_b_q       <= fill_b_d;
      flag_q         <= flag_d;
      result_valid_o <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ia_q  <= ia_d;
    ib_q  <= ib_d;
    cnt_q <= cnt_d;
    tot_q <= tot_d;
    if ((state_q == S_IDLE) && start_i) begin
      sel_q  <= list_select_i;
      id_q   <= product_id_i;
      pr_q   <= price_i;
      last_q <= last_item_i;
    end
    if (state_q == S_MRG) begin
      product_id_res_o <= pick_a ? aid : bid;
      price_res_o      <= opr;
      source_list_o    <= ~pick_a;
      running_count_o  <= cnt_d;
      running_total_o  <= tot_d;
      overflow_o       <= flag_q;
      last_result_o    <= (ia_d >= fill_a_q) && (ib_d >= fill_b_q);
    end
  end

endmodule

// ===== rtl/smdmp_checker.sv =====
// ----------------------------------------------------------------------------
// smdmp_checker
// Port-level checks on the merge output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module smdmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy_o,
  input logic                        result_valid_o,
  input logic [smdmp_pkg::CNT_W-1:0] running_count_o,
  input logic                        last_result_o
);

  // results come only out of a merge in progress
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without preceding busy");

  // merge results stream back to back until the last one
  a_res_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> result_valid_o)
    else $error("gap in merge result stream");

  // count steps by one within a merge
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=>
      running_count_o == $past(running_count_o) + smdmp_pkg::CNT_W'(1))
    else $error("running count did not advance by one");

  // block is free when the final result shows
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |-> !busy_o)
    else $error("busy still high at final result");

endmodule

bind sorted_merge_dedup_min_price smdmp_checker u_smdmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .running_count_o(running_count_o),
  .last_result_o  (last_result_o)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_merge_dedup_min_price: a directed table and
// random load/merge batches, checked against a behavioral list-merge model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import smdmp_pkg::*;

  localparam int unsigned DEPTH     = LIST_DEPTH_DEF;
  localparam int unsigned IDLE_LIM  = 20000;
  localparam int unsigned N_RANDOM  = 460;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PR_W-1:0]  pr;
    logic             src;
    logic [CNT_W-1:0] cnt;
    logic [TOT_W-1:0] tot;
    logic             ovf;
    logic             lst;
  } merged_rec_t;

  typedef struct packed {
    logic            sel;
    logic [ID_W-1:0] id;
    logic [PR_W-1:0] pr;
    logic            lst;
    logic            chk_first;  // first result typed in below
    merged_rec_t     first_rec;
  } load_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             list_select_i = 1'b0;
  logic [ID_W-1:0]  product_id_i = '0;
  logic [PR_W-1:0]  price_i = '0;
  logic             last_item_i = 1'b0;
  logic             result_valid_o;
  logic [ID_W-1:0]  product_id_res_o;
  logic [PR_W-1:0]  price_res_o;
  logic             source_list_o;
  logic [CNT_W-1:0] running_count_o;
  logic [TOT_W-1:0] running_total_o;
  logic             overflow_o;
  logic             last_result_o;

  sorted_merge_dedup_min_price dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  logic [ID_W-1:0] a_ids [DEPTH];
  logic [PR_W-1:0] a_prs [DEPTH];
  logic [ID_W-1:0] b_ids [DEPTH];
  logic [PR_W-1:0] b_prs [DEPTH];
  int unsigned     a_fill = 0, b_fill = 0;
  logic            drop_seen = 1'b0;

  merged_rec_t merged_q[$];
  merged_rec_t typed_q[$];   // hand-written expectations, paired by position
  int          typed_pos[$];
  int unsigned errors = 0, n_results = 0, n_loads = 0, n_merges = 0;
  int unsigned idle_cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // sorted insert into one list; drop sets the sticky flag
  task automatic insert_rec(input logic sel, input logic [ID_W-1:0] id,
                            input logic [PR_W-1:0] pr);
    int unsigned n, pos;
    n = sel ? b_fill : a_fill;
    if (n >= DEPTH) begin
      drop_seen = 1'b1;
      return;
    end
    if (sel) begin
      if (n == 0 || id < b_ids[0]) pos = 0;
      else begin
        pos = 1;
        while (pos < n && b_ids[pos] < id) pos++;
      end
      for (int k = n; k > pos; k--) begin
        b_ids[k] = b_ids[k-1];
        b_prs[k] = b_prs[k-1];
      end
      b_ids[pos] = id; b_prs[pos] = pr; b_fill++;
    end else begin
      if (n == 0 || id < a_ids[0]) pos = 0;
      else begin
        pos = 1;
        while (pos < n && a_ids[pos] < id) pos++;
      end
      for (int k = n; k > pos; k--) begin
        a_ids[k] = a_ids[k-1];
        a_prs[k] = a_prs[k-1];
      end
      a_ids[pos] = id; a_prs[pos] = pr; a_fill++;
    end
  endtask

  // insert; on a last record, merge with duplicate removal and queue every merged record
  task automatic predict_load(input logic sel, input logic [ID_W-1:0] id,
                              input logic [PR_W-1:0] pr, input logic lst);
    int unsigned ia, ib;
    merged_rec_t r;
    insert_rec(sel, id, pr);
    n_loads++;
    if (!lst) return;
    ia = 0; ib = 0; r = '0;
    while (ia < a_fill || ib < b_fill) begin
      if (ib >= b_fill || (ia < a_fill && a_ids[ia] < b_ids[ib])) begin
        r.id = a_ids[ia]; r.pr = a_prs[ia]; r.src = 1'b0; ia++;
      end else if (ia >= a_fill || a_ids[ia] > b_ids[ib]) begin
        r.id = b_ids[ib]; r.pr = b_prs[ib]; r.src = 1'b1; ib++;
      end else begin
        if (a_prs[ia] <= b_prs[ib]) begin
          r.id = a_ids[ia]; r.pr = a_prs[ia]; r.src = 1'b0;
        end else begin
          r.id = b_ids[ib]; r.pr = b_prs[ib]; r.src = 1'b1;
        end
        ia++; ib++;
      end
      r.cnt++;
      r.tot += TOT_W'(r.pr);
      r.ovf = drop_seen;
      r.lst = 1'b0;
      merged_q.push_back(r);
    end
    merged_q[merged_q.size()-1].lst = 1'b1;
    a_fill = 0; b_fill = 0; drop_seen = 1'b0;
    n_merges++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    merged_rec_t got, exp;
    if (rst_ni && result_valid_o) begin
      got = '{product_id_res_o, price_res_o, source_list_o, running_count_o,
              running_total_o, overflow_o, last_result_o};
      n_results++;
      if (merged_q.size() == 0) report("result with nothing expected");
      else begin
        exp = merged_q.pop_front();
        if (got.id  !== exp.id)  report($sformatf("id %h exp %h", got.id, exp.id));
        if (got.pr  !== exp.pr)  report($sformatf("price %h exp %h", got.pr, exp.pr));
        if (got.src !== exp.src) report($sformatf("source %b exp %b", got.src, exp.src));
        if (got.cnt !== exp.cnt) report($sformatf("count %0d exp %0d", got.cnt, exp.cnt));
        if (got.tot !== exp.tot) report($sformatf("total %0d exp %0d", got.tot, exp.tot));
        if (got.ovf !== exp.ovf) report($sformatf("overflow %b exp %b", got.ovf, exp.ovf));
        if (got.lst !== exp.lst) report($sformatf("last %b exp %b", got.lst, exp.lst));
      end
      if (typed_pos.size() != 0 && typed_pos[0] == n_results) begin
        void'(typed_pos.pop_front());
        if (got !== typed_q.pop_front()) report("first result differs from table");
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIM) begin
      $display("[sorted_merge_dedup_min_price] ERROR");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  // one transfer, with bursts and random gaps ahead of it; start stays high
  // between back-to-back transfers and drops only for a gap
  task automatic send(input logic sel, input logic [ID_W-1:0] id,
                      input logic [PR_W-1:0] pr, input logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    start_i       <= 1'b1;
    list_select_i <= sel;
    product_id_i  <= id;
    price_i       <= pr;
    last_item_i   <= lst;
    predict_load(sel, id, pr, lst);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic load_row_t row(input int sel, input int id, input int pr,
                                    input int lst);
    row = '{1'(sel), ID_W'(id), PR_W'(pr), 1'(lst), 1'b0, '0};
  endfunction

  load_row_t   dir_tab[$];
  int unsigned nb, base;
  logic [ID_W-1:0] rid;

  initial begin
    // single record, extremes, typed expectation
    dir_tab.push_back('{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                        '{16'hFFFF, 16'hFFFF, 1'b0, 7'd1, 22'd65535, 1'b0, 1'b1}});
    dir_tab.push_back('{1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1,
                        '{16'h0000, 16'h0000, 1'b1, 7'd1, 22'd0, 1'b0, 1'b1}});
    // equal ids across lists: lower price, A on tie
    dir_tab.push_back(row(0, 100, 50, 0));
    dir_tab.push_back(row(1, 100, 40, 0));
    dir_tab.push_back(row(0, 200, 7, 0));
    dir_tab.push_back(row(1, 200, 7, 0));
    dir_tab.push_back(row(1, 50, 1, 0));
    dir_tab.push_back(row(0, 300, 16'hFFFF, 1));
    // equal ids within one list, including equal to head
    dir_tab.push_back(row(0, 10, 1, 0));
    dir_tab.push_back(row(0, 10, 2, 0));
    dir_tab.push_back(row(0, 10, 3, 0));
    dir_tab.push_back(row(0, 5, 4, 0));
    dir_tab.push_back(row(0, 12, 5, 0));
    dir_tab.push_back(row(1, 10, 0, 1));
    // empty list A, last record to B
    dir_tab.push_back(row(1, 16'h5555, 16'hAAAA, 0));
    dir_tab.push_back(row(1, 16'hAAAA, 16'h5555, 1));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].chk_first) begin
        typed_pos.push_back(n_results + merged_q.size() + 1);
        typed_q.push_back(dir_tab[i].first_rec);
      end
      send(dir_tab[i].sel, dir_tab[i].id, dir_tab[i].pr, dir_tab[i].lst);
    end

    // full lists: fill both, overflow, then merge (dropped last record too)
    for (int i = 0; i < DEPTH + 2; i++) send(1'b0, ID_W'($urandom), 16'hFFFF, 1'b0);
    for (int i = 0; i < DEPTH; i++) send(1'b1, ID_W'($urandom), 16'hFFFF, 1'b0);
    send(1'b1, 16'h1234, 16'h0001, 1'b1);

    // random batches: mostly modest sizes, narrow id range for collisions
    while (n_loads < N_RANDOM + dir_tab.size()) begin
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      base = $urandom;
      for (int i = 0; i < nb; i++) begin
        rid = ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                          : ID_W'(base + $urandom_range(0, 15));
        send(1'($urandom_range(0, 1)), rid, PR_W'($urandom), i == nb - 1);
      end
    end
    start_i <= 1'b0;

    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    $display("loaded %0d records in %0d merges, checked %0d merged records",
             n_loads, n_merges, n_results);
    if (errors == 0 && typed_q.size() == 0) begin
      $display("[sorted_merge_dedup_min_price] OK");
    end else begin
      $display("[sorted_merge_dedup_min_price] ERROR");
    end
    $finish;
  end

endmodule
